@@ hdl/sorted_slot_linked_list_assert.svh @@
// assertion macros for the sorted slot linked list
// clocked on clk_i, disabled while rst_ni is low
`ifndef SORTED_SLOT_LINKED_LIST_ASSERT_SVH
`define SORTED_SLOT_LINKED_LIST_ASSERT_SVH

// consequent checked in the same cycle
`define SSLL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssll assertion failed");

// consequent checked in the next cycle
`define SSLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssll assertion failed");

`endif

@@ hdl/ssll_pkg.sv @@
package ssll_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

endpackage

@@ hdl/sorted_slot_linked_list.sv @@
// sequence: remove, search and update walk the list one node per cycle, then apply and report;
//   an insert walks the list, writes the new slot, links its predecessor and scans for a free slot
// throughput: one request at a time; the next request is taken once the block is back in idle,
//   set by the single-read-port chain walk and the one-slot-per-cycle free-slot scan
// reset: asynchronous, active low; list empty, all slots free, head and tail at slot zero;
//   slot storage needs no clearing pass
`include "sorted_slot_linked_list_assert.svh"

module sorted_slot_linked_list
  import ssll_pkg::*;
#(
  parameter int ENTRIES   = 32,
  parameter int KEY_BITS  = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [KEY_BITS-1:0]        key_i,
  input  logic [DATA_BITS-1:0]       payload_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic                       found_o,
  output logic [$clog2(ENTRIES)-1:0] slot_o,
  output logic [DATA_BITS-1:0]       payload_out_o,
  output logic                       is_empty_o,
  output logic [$clog2(ENTRIES)-1:0] head_slot_o,
  output logic [$clog2(ENTRIES)-1:0] tail_slot_o
);

  localparam int IDX_W = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_APPLY,
    S_LINK,
    S_SCAN,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // slot storage: one write port and one registered read port per array
  // ---------------------------------------------------------------------------
  logic [KEY_BITS-1:0]  key_mem [ENTRIES];
  logic [DATA_BITS-1:0] pay_mem [ENTRIES];
  logic [IDX_W-1:0]     nxt_mem [ENTRIES];

  logic [KEY_BITS-1:0]  rd_key_q;
  logic [DATA_BITS-1:0] rd_pay_q;
  logic [IDX_W-1:0]     rd_next_q;
  logic [IDX_W-1:0]     rd_addr;

  logic                 key_we;
  logic                 pay_we;
  logic [IDX_W-1:0]     pay_wa;
  logic                 nxt_we;
  logic [IDX_W-1:0]     nxt_wa;
  logic [IDX_W-1:0]     nxt_wd;

  // ---------------------------------------------------------------------------
  // sequencer and list state
  // ---------------------------------------------------------------------------
  state_e               state_q;
  opcode_e              op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] data_q;

  // walk position: cur_q is the node whose data sits in the read registers
  logic [IDX_W-1:0]     cur_q;
  logic [IDX_W-1:0]     prev_q;

  // first match in list order
  logic                 hit_q;
  logic [IDX_W-1:0]     at_q;
  logic [IDX_W-1:0]     before_q;
  logic [IDX_W-1:0]     at_next_q;
  logic [DATA_BITS-1:0] pay_hit_q;

  // insertion point: new slot goes between ins_prev_q and ins_next_q
  logic [IDX_W-1:0]     ins_prev_q;
  logic [IDX_W-1:0]     ins_next_q;
  logic                 new_head_q;
  logic                 new_tail_q;

  logic [IDX_W-1:0]     head_q;
  logic [IDX_W-1:0]     tail_q;
  logic                 empty_q;
  logic [IDX_W-1:0]     lf_q;       // lowest free slot, zero when all in use
  logic [ENTRIES-1:0]   used_q;
  logic [IDX_W:0]       scan_q;     // one bit wider to reach ENTRIES

  status_e              res_status_q;
  logic [IDX_W-1:0]     res_slot_q;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic                 found_q;
  logic [IDX_W-1:0]     slot_q;
  logic [DATA_BITS-1:0] payload_out_q;
  logic                 is_empty_q;
  logic [IDX_W-1:0]     head_slot_q;
  logic [IDX_W-1:0]     tail_slot_q;

  // walk compares against the node just read
  logic                 key_match;
  logic                 key_less;
  logic                 wrap;
  logic                 table_full;
  logic [IDX_W-1:0]     scan_idx;

  assign key_match  = (key_q == rd_key_q);
  assign key_less   = (key_q < rd_key_q);
  assign wrap       = (rd_next_q == head_q);
  assign table_full = used_q[lf_q];
  assign scan_idx   = scan_q[IDX_W-1:0];

  assign in_ready_o = (state_q == S_IDLE);

  // read address: head at the start of a walk, then follow the link just read
  always_comb begin
    rd_addr = head_q;
    if (state_q == S_WALK) begin
      rd_addr = rd_next_q;
    end
  end

  // write ports driven by the sequencer
  always_comb begin
    key_we = 1'b0;
    pay_we = 1'b0;
    pay_wa = lf_q;
    nxt_we = 1'b0;
    nxt_wa = lf_q;
    nxt_wd = ins_next_q;
    case (state_q)
      S_APPLY: begin
        case (op_q)
          OP_INSERT: begin
            if (!table_full) begin
              key_we = 1'b1;
              pay_we = 1'b1;
              nxt_we = 1'b1;
              // a lone entry links to itself
              nxt_wd = empty_q ? lf_q : ins_next_q;
            end
          end
          OP_REMOVE: begin
            if (hit_q && (head_q != tail_q)) begin
              nxt_we = 1'b1;
              nxt_wa = before_q;
              nxt_wd = at_next_q;
            end
          end
          OP_UPDATE: begin
            if (hit_q) begin
              pay_we = 1'b1;
              pay_wa = at_q;
            end
          end
          OP_SEARCH: begin
          end
          default: begin
          end
        endcase
      end
      S_LINK: begin
        // predecessor now points at the new slot
        nxt_we = 1'b1;
        nxt_wa = ins_prev_q;
        nxt_wd = res_slot_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[lf_q] <= key_q;
    end
    rd_key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= data_q;
    end
    rd_pay_q <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    rd_next_q <= nxt_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // sequencer: state, list pointers and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OP_INSERT;
      key_q         <= '0;
      data_q        <= '0;
      cur_q         <= '0;
      prev_q        <= '0;
      hit_q         <= 1'b0;
      at_q          <= '0;
      before_q      <= '0;
      at_next_q     <= '0;
      pay_hit_q     <= '0;
      ins_prev_q    <= '0;
      ins_next_q    <= '0;
      new_head_q    <= 1'b0;
      new_tail_q    <= 1'b0;
      head_q        <= '0;
      tail_q        <= '0;
      empty_q       <= 1'b1;
      lf_q          <= '0;
      used_q        <= '0;
      scan_q        <= '0;
      res_status_q  <= ST_DONE;
      res_slot_q    <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= '0;
      found_q       <= 1'b0;
      slot_q        <= '0;
      payload_out_q <= '0;
      is_empty_q    <= 1'b1;
      head_slot_q   <= '0;
      tail_slot_q   <= '0;
    end else begin
      // in S_DONE the result register is refilled or held below
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q   <= opcode_e'(opcode_i);
            key_q  <= key_i;
            data_q <= payload_i;
            hit_q  <= 1'b0;
            // head is read this cycle, its predecessor is the tail
            cur_q  <= head_q;
            prev_q <= tail_q;
            // empty list: nothing to walk, a lone insert lands directly
            new_head_q <= 1'b0;
            new_tail_q <= 1'b0;
            state_q    <= empty_q ? S_APPLY : S_WALK;
          end
        end

        S_WALK: begin
          if (!hit_q && key_match) begin
            hit_q     <= 1'b1;
            at_q      <= cur_q;
            before_q  <= prev_q;
            at_next_q <= rd_next_q;
            pay_hit_q <= rd_pay_q;
          end
          if (op_q == OP_INSERT) begin
            // equal keys are passed over so the new one lands after them
            if (key_less) begin
              ins_prev_q <= prev_q;
              ins_next_q <= cur_q;
              new_head_q <= (cur_q == head_q);
              new_tail_q <= 1'b0;
              state_q    <= S_APPLY;
            end else if (wrap) begin
              // larger than everything: append after the tail
              ins_prev_q <= cur_q;
              ins_next_q <= head_q;
              new_head_q <= 1'b0;
              new_tail_q <= 1'b1;
              state_q    <= S_APPLY;
            end else begin
              prev_q <= cur_q;
              cur_q  <= rd_next_q;
            end
          end else begin
            // sorted order: a larger key means the key is absent
            if (key_match || key_less || wrap) begin
              state_q <= S_APPLY;
            end else begin
              prev_q <= cur_q;
              cur_q  <= rd_next_q;
            end
          end
        end

        S_APPLY: begin
          case (op_q)
            OP_INSERT: begin
              if (table_full) begin
                res_status_q <= ST_FULL;
                res_slot_q   <= '0;
                state_q      <= S_DONE;
              end else begin
                res_status_q <= ST_DONE;
                res_slot_q   <= lf_q;
                used_q[lf_q] <= 1'b1;
                // every slot below the one just taken is in use
                scan_q       <= {1'b0, lf_q} + {{IDX_W{1'b0}}, 1'b1};
                if (empty_q) begin
                  head_q  <= lf_q;
                  tail_q  <= lf_q;
                  empty_q <= 1'b0;
                  state_q <= S_SCAN;
                end else begin
                  if (new_head_q) begin
                    head_q <= lf_q;
                  end
                  if (new_tail_q) begin
                    tail_q <= lf_q;
                  end
                  state_q <= S_LINK;
                end
              end
            end
            OP_REMOVE, OP_SEARCH, OP_UPDATE: begin
              if (!hit_q) begin
                res_status_q <= ST_NOT_FOUND;
                res_slot_q   <= '0;
              end else begin
                res_status_q <= ST_DONE;
                res_slot_q   <= at_q;
                if (op_q == OP_REMOVE) begin
                  if (head_q == tail_q) begin
                    // last entry gone
                    empty_q <= 1'b1;
                    head_q  <= '0;
                    tail_q  <= '0;
                  end else begin
                    if (at_q == head_q) begin
                      head_q <= at_next_q;
                    end
                    if (at_q == tail_q) begin
                      tail_q <= before_q;
                    end
                  end
                  used_q[at_q] <= 1'b0;
                  // when the table was full the freed slot is the only free one
                  if (table_full || (at_q < lf_q)) begin
                    lf_q <= at_q;
                  end
                end
              end
              state_q <= S_DONE;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end

        S_LINK: begin
          state_q <= S_SCAN;
        end

        S_SCAN: begin
          // one slot per cycle upwards from the slot just taken
          if (scan_q == (IDX_W + 1)'(ENTRIES)) begin
            lf_q    <= '0;
            state_q <= S_DONE;
          end else if (!used_q[scan_idx]) begin
            lf_q    <= scan_idx;
            state_q <= S_DONE;
          end else begin
            scan_q <= scan_q + {{IDX_W{1'b0}}, 1'b1};
          end
        end

        S_DONE: begin
          // wait for the result register to be free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            status_q      <= res_status_q;
            found_q       <= hit_q;
            slot_q        <= res_slot_q;
            payload_out_q <= ((op_q != OP_INSERT) && hit_q) ? pay_hit_q : '0;
            is_empty_q    <= empty_q;
            head_slot_q   <= head_q;
            tail_slot_q   <= tail_q;
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign slot_o        = slot_q;
  assign payload_out_o = payload_out_q;
  assign is_empty_o    = is_empty_q;
  assign head_slot_o   = head_slot_q;
  assign tail_slot_o   = tail_slot_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an accepted request keeps the block busy for at least the next cycle
  `SSLL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // an empty list parks head and tail at slot zero
  `SSLL_ASSERT_NOW(a_empty_ptrs, empty_q, (head_q == '0) && (tail_q == '0))
  // between requests the lowest free slot really is free, unless all are in use
  `SSLL_ASSERT_NOW(a_free_slot, state_q == S_IDLE, !used_q[lf_q] || (&used_q))
  // a refused insert reports no slot and no payload
  `SSLL_ASSERT_NOW(a_full_result, out_valid_o && (status_o == ST_FULL),
                   (slot_o == '0) && (payload_out_o == '0))

endmodule

@@ verif/tb_sorted_slot_linked_list.sv @@
`timescale 1ns / 100ps

module tb_sorted_slot_linked_list
  import ssll_pkg::*;
;

  localparam int SLOTS  = 32;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int SLOT_W = $clog2(SLOTS);

  // worst single request: chain walk, link write and free-slot scan
  localparam int DRAIN_CYCLES = 2 * SLOTS + 40;
  // one long receiver hold-off so the block backs up and stalls its input
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    opcode_e           op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } request_t;

  typedef struct {
    status_e           status;
    bit                found;
    bit [SLOT_W-1:0]   slot;
    bit [DATA_W-1:0]   data;
    bit                empty;
    bit [SLOT_W-1:0]   head;
    bit [SLOT_W-1:0]   tail;
  } outcome_t;

  // clock, reset and block inputs, all at known values from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [1:0]          opcode_i      = OP_SEARCH;
  logic [KEY_W-1:0]    key_i         = '0;
  logic [DATA_W-1:0]   payload_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [1:0]          status_o;
  logic                found_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [DATA_W-1:0]   payload_out_o;
  logic                is_empty_o;
  logic [SLOT_W-1:0]   head_slot_o;
  logic [SLOT_W-1:0]   tail_slot_o;

  // stimulus and scoreboard bookkeeping
  request_t  request_q[$];
  outcome_t  outcome_q[$];
  int        stim_total   = 0;
  int        accepted_cnt = 0;
  int        result_cnt   = 0;
  int        err_cnt      = 0;
  bit        req_taken    = 1'b0;
  int        hold_left    = 0;
  bit        hold_done    = 1'b0;

  // shadow of the slot table, kept in step with every accepted request
  bit [KEY_W-1:0]  ent_key  [SLOTS];
  bit [DATA_W-1:0] ent_data [SLOTS];
  int              ent_next [SLOTS];
  bit              ent_used [SLOTS];
  int              head_idx    = 0;
  int              tail_idx    = 0;
  int              free_idx    = 0;
  bit              chain_empty = 1'b1;

  sorted_slot_linked_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .slot_o        (slot_o),
    .payload_out_o (payload_out_o),
    .is_empty_o    (is_empty_o),
    .head_slot_o   (head_slot_o),
    .tail_slot_o   (tail_slot_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow table behaviour
  // ---------------------------------------------------------------------------

  // walk the circular chain from the head; on a hit give the slot and its predecessor
  function automatic bit locate_key(input bit [KEY_W-1:0] key, output int at, output int prev);
    int cur;
    at   = 0;
    prev = 0;
    if (chain_empty) return 1'b0;
    cur  = head_idx;
    prev = tail_idx;
    for (int n = 0; n < SLOTS; n++) begin
      if (ent_key[cur] == key) begin
        at = cur;
        return 1'b1;
      end
      prev = cur;
      cur  = ent_next[cur];
      if (cur == head_idx) break;
    end
    return 1'b0;
  endfunction

  // lowest unused slot, or zero when every slot is taken
  function automatic void rescan_free();
    free_idx = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!ent_used[i]) begin
        free_idx = i;
        return;
      end
    end
  endfunction

  // link slot s before the first strictly larger key, so equal keys queue up behind
  function automatic void link_entry(input int s, input bit [KEY_W-1:0] key);
    int prev;
    int cur;
    if (chain_empty) begin
      head_idx    = s;
      tail_idx    = s;
      ent_next[s] = s;
      chain_empty = 1'b0;
      return;
    end
    if (key < ent_key[head_idx]) begin
      ent_next[s]        = head_idx;
      ent_next[tail_idx] = s;
      head_idx           = s;
      return;
    end
    prev = head_idx;
    cur  = ent_next[head_idx];
    for (int n = 0; n < SLOTS; n++) begin
      if (cur == head_idx) break;
      if (key < ent_key[cur]) begin
        ent_next[prev] = s;
        ent_next[s]    = cur;
        return;
      end
      prev = cur;
      cur  = ent_next[cur];
    end
    // largest key so far: becomes the new tail
    ent_next[tail_idx] = s;
    ent_next[s]        = head_idx;
    tail_idx           = s;
  endfunction

  // apply one request to the shadow table and return the result the block owes us
  function automatic outcome_t predict_outcome(input opcode_e op, input bit [KEY_W-1:0] key,
                                               input bit [DATA_W-1:0] data);
    outcome_t res;
    int       at;
    int       prev;
    int       s;
    bit       hit;
    hit        = locate_key(key, at, prev);
    res.status = ST_DONE;
    res.found  = hit;
    res.slot   = '0;
    res.data   = '0;
    if (op == OP_INSERT) begin
      s = free_idx;
      if (ent_used[s]) begin
        // table full: refused, nothing moves
        res.status = ST_FULL;
      end else begin
        ent_key[s]  = key;
        ent_data[s] = data;
        ent_used[s] = 1'b1;
        link_entry(s, key);
        rescan_free();
        res.slot = SLOT_W'(s);
      end
    end else if (!hit) begin
      res.status = ST_NOT_FOUND;
    end else begin
      res.slot = SLOT_W'(at);
      res.data = ent_data[at];
      if (op == OP_REMOVE) begin
        if (head_idx == tail_idx) begin
          // last entry gone: pointers fall back to slot zero
          chain_empty = 1'b1;
          head_idx    = 0;
          tail_idx    = 0;
        end else begin
          ent_next[prev] = ent_next[at];
          if (at == head_idx) head_idx = ent_next[at];
          if (at == tail_idx) tail_idx = prev;
        end
        ent_used[at] = 1'b0;
        rescan_free();
      end else if (op == OP_UPDATE) begin
        ent_data[at] = data;
      end
    end
    res.empty = chain_empty;
    res.head  = chain_empty ? '0 : SLOT_W'(head_idx);
    res.tail  = chain_empty ? '0 : SLOT_W'(tail_idx);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_request(input opcode_e op, input bit [KEY_W-1:0] key,
                             input bit [DATA_W-1:0] data);
    request_t r;
    r.op   = op;
    r.key  = key;
    r.data = data;
    request_q.push_back(r);
  endtask

  // idle share in percent: sender 37 / receiver 50, then swapped, then no idling
  function automatic int idle_pct(input bit sender_side);
    if (accepted_cnt * 3 < stim_total) return sender_side ? 37 : 50;
    if (accepted_cnt * 3 < stim_total * 2) return sender_side ? 50 : 37;
    return 0;
  endfunction

  // request driver: a new request only once the previous one has been taken
  always @(negedge clk_i) begin : request_driver
    request_t nxt;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        nxt = request_q.pop_front();
        in_valid_i <= 1'b1;
        opcode_i   <= nxt.op;
        key_i      <= nxt.key;
        payload_i  <= nxt.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus a single long hold-off, counted here
  always @(negedge clk_i) begin : result_sink
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and scoreboard: results checked before the new request is predicted,
  // a result can never belong to a request taken at the same edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_monitor
    outcome_t want;
    req_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result %0d: no request outstanding (status %0d slot %0d)",
                     result_cnt, status_o, slot_o);
        end else begin
          want = outcome_q.pop_front();
          if (status_o !== want.status || found_o !== want.found || slot_o !== want.slot ||
              payload_out_o !== want.data || is_empty_o !== want.empty ||
              head_slot_o !== want.head || tail_slot_o !== want.tail) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch on result %0d", result_cnt);
              $display("  expected status %0d found %0b slot %0d data %h empty %0b head %0d tail %0d",
                       want.status, want.found, want.slot, want.data, want.empty,
                       want.head, want.tail);
              $display("  actual   status %0d found %0b slot %0d data %h empty %0b head %0d tail %0d",
                       status_o, found_o, slot_o, payload_out_o, is_empty_o,
                       head_slot_o, tail_slot_o);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        outcome_q.push_back(predict_outcome(opcode_e'(opcode_i), key_i, payload_i));
        accepted_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    bit [KEY_W-1:0] key_pool[$];
    bit [KEY_W-1:0] k;
    opcode_e        op;
    int             mode;
    int             run_len;
    int             roll;
    int             made;

    // directed: empty table behaviour
    add_request(OP_SEARCH, 16'h1234, 32'h0000_0000);
    add_request(OP_REMOVE, 16'h0000, 32'h0000_0000);
    add_request(OP_UPDATE, 16'hFFFF, 32'hFFFF_FFFF);
    // directed: first entry, new tail, new head, equal key behind its twin, middle
    add_request(OP_INSERT, 16'h8000, 32'h1111_1111);
    add_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 16'h0000, 32'h0000_0000);
    add_request(OP_INSERT, 16'h8000, 32'h2222_2222);
    add_request(OP_INSERT, 16'h4000, 32'h8000_0001);
    // directed: hits and misses on search and update
    add_request(OP_SEARCH, 16'h8000, 32'h0000_0000);
    add_request(OP_UPDATE, 16'h8000, 32'hA5A5_A5A5);
    add_request(OP_SEARCH, 16'h8000, 32'hFFFF_FFFF);
    add_request(OP_SEARCH, 16'h1234, 32'h0000_0000);
    add_request(OP_UPDATE, 16'h7FFF, 32'h5A5A_5A5A);
    // directed: unlink head, tail, first of two twins, a missing key, then drain to empty
    add_request(OP_REMOVE, 16'h0000, 32'h0000_0000);
    add_request(OP_REMOVE, 16'hFFFF, 32'h0000_0000);
    add_request(OP_REMOVE, 16'h8000, 32'h0000_0000);
    add_request(OP_REMOVE, 16'h0001, 32'h0000_0000);
    add_request(OP_SEARCH, 16'h8000, 32'h0000_0000);
    add_request(OP_REMOVE, 16'h4000, 32'h0000_0000);
    add_request(OP_REMOVE, 16'h8000, 32'h0000_0000);
    add_request(OP_SEARCH, 16'h4000, 32'h0000_0000);

    // random: open with a burst of inserts so the table fills and refuses a few
    made = 0;
    repeat (SLOTS + 4) begin
      k = KEY_W'($urandom_range(16'hFFFF));
      key_pool.push_back(k);
      add_request(OP_INSERT, k, $urandom());
      made++;
    end

    // then episodes biased towards filling, draining or an even mix; keys mostly
    // reuse earlier inserts so removes, searches and updates actually hit
    while (made < 1600) begin
      mode    = $urandom_range(2);
      run_len = $urandom_range(20, 80);
      repeat (run_len) begin
        roll = $urandom_range(99);
        case (mode)
          0: op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_REMOVE :
                  (roll < 90) ? OP_SEARCH : OP_UPDATE;
          1: op = (roll < 15) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                  (roll < 85) ? OP_SEARCH : OP_UPDATE;
          default: op = opcode_e'($urandom_range(3));
        endcase
        roll = $urandom_range(99);
        if (roll < 60 && key_pool.size() != 0)
          k = key_pool[$urandom_range(key_pool.size() - 1)];
        else if (roll < 80)
          k = KEY_W'($urandom_range(7));
        else
          k = KEY_W'($urandom_range(16'hFFFF));
        if (op == OP_INSERT) begin
          key_pool.push_back(k);
          if (key_pool.size() > 48) void'(key_pool.pop_front());
        end
        add_request(op, k, $urandom());
        made++;
      end
    end
    stim_total = request_q.size();

    // reset released on a falling edge, clear of the sampling edge
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // every request taken and answered, then a quiet spell for stray results
    while (accepted_cnt < stim_total || outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
